// File: rtl/flac_pkg.sv
// shared types and constants of the fuel level adc conditioner
package flac_pkg;

	localparam int ADC_BITS = 12;
	localparam int HEIGHT_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int FRAC_BITS = 8;
	localparam int SMOOTH_W = ADC_BITS + FRAC_BITS;
	localparam int HISTORY_DEPTH_DEF = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam int NUM_ANCHORS = 5;
	localparam int SPAN_W = ADC_BITS + 2;
	localparam int NUM_W = HEIGHT_W + SPAN_W;
	localparam int DIV_STEPS = HEIGHT_W;

	localparam logic [ADC_BITS-1:0] RAIL_HIGH = ADC_BITS'(4090);
	localparam logic [ADC_BITS-1:0] RAIL_LOW = ADC_BITS'(5);
	localparam logic [ADC_BITS:0] FAR_MARGIN = (ADC_BITS+1)'(300);
	localparam int SLEW_LIMIT = 80 * (1 << FRAC_BITS);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAL_EMPTY = 3'd0,
		CFG_CAL_QUARTER = 3'd1,
		CFG_CAL_HALF = 3'd2,
		CFG_CAL_THREE_QUARTER = 3'd3,
		CFG_CAL_FULL = 3'd4,
		CFG_TANK_DIAMETER = 3'd5,
		CFG_UNREACHED_HEIGHT = 3'd6,
		CFG_REACH_HEIGHT = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_ONLINE = 2'd0,
		ST_SENSOR_FAULT = 2'd1,
		ST_NOT_MONOTONIC = 2'd2,
		ST_GEOMETRY_INVALID = 2'd3
	} status_t;

	typedef struct packed {
		logic [ADC_BITS-1:0] cal_empty;
		logic [ADC_BITS-1:0] cal_quarter;
		logic [ADC_BITS-1:0] cal_half;
		logic [ADC_BITS-1:0] cal_three_quarter;
		logic [ADC_BITS-1:0] cal_full;
		logic [HEIGHT_W-1:0] tank_diameter;
		logic [HEIGHT_W-1:0] unreached_height;
		logic [HEIGHT_W-1:0] reach_height;
	} cfg_t;

	// one queue entry: filtered reading, or raw reading when fault is set
	typedef struct packed {
		logic fault;
		logic [ADC_BITS-1:0] value;
	} work_t;

endpackage

// File: rtl/flac_ifs.sv
// stream and configuration channel interfaces
interface flac_sample_if;
	import flac_pkg::*;
	logic valid;
	logic ready;
	logic [ADC_BITS-1:0] adc_sample;
	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface flac_result_if;
	import flac_pkg::*;
	logic valid;
	logic ready;
	logic [ADC_BITS-1:0] filtered_raw;
	logic [HEIGHT_W-1:0] liquid_height;
	status_t status;
	modport source (output valid, output filtered_raw, output liquid_height, output status,
		input ready);
	modport sink (input valid, input filtered_raw, input liquid_height, input status,
		output ready);
endinterface

interface flac_cfg_if;
	import flac_pkg::*;
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/fuel_level_adc_conditioner_top.sv
// top level: configuration registers, front end, queue and back end
// Each accepted sample gives exactly one result beat. The front end takes a
// sample, ranks the history one entry per cycle for the median and runs the ema
// update; a fault sample skips the ranking and the ema and is passed on raw.
// The back end turns a filtered reading into a height with a segment search, a
// multiply and a bit-serial restoring divider, one reading at a time; results
// with a fault or error status, and readings outside the calibrated range,
// skip the multiply and divide. A two-beat queue between the halves lets the
// front end take new samples while the back end divides or its result waits.
// Configuration writes are taken every cycle and must only come while idle.
module fuel_level_adc_conditioner_top #(
	parameter int HISTORY_DEPTH = flac_pkg::HISTORY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	flac_sample_if.sink sample,
	flac_result_if.source result,
	flac_cfg_if.sink cfg
);
	import flac_pkg::*;

	cfg_t regs_q;
	logic push_valid, push_ready, pop_valid, pop_ready;
	work_t push_data, pop_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.cal_empty <= ADC_BITS'(0);
			regs_q.cal_quarter <= ADC_BITS'(1024);
			regs_q.cal_half <= ADC_BITS'(2048);
			regs_q.cal_three_quarter <= ADC_BITS'(3072);
			regs_q.cal_full <= ADC_BITS'(4095);
			regs_q.tank_diameter <= '0;
			regs_q.unreached_height <= '0;
			regs_q.reach_height <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_CAL_EMPTY: regs_q.cal_empty <= cfg.data[ADC_BITS-1:0];
				CFG_CAL_QUARTER: regs_q.cal_quarter <= cfg.data[ADC_BITS-1:0];
				CFG_CAL_HALF: regs_q.cal_half <= cfg.data[ADC_BITS-1:0];
				CFG_CAL_THREE_QUARTER: regs_q.cal_three_quarter <= cfg.data[ADC_BITS-1:0];
				CFG_CAL_FULL: regs_q.cal_full <= cfg.data[ADC_BITS-1:0];
				CFG_TANK_DIAMETER: regs_q.tank_diameter <= cfg.data[HEIGHT_W-1:0];
				CFG_UNREACHED_HEIGHT: regs_q.unreached_height <= cfg.data[HEIGHT_W-1:0];
				CFG_REACH_HEIGHT: regs_q.reach_height <= cfg.data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	flac_front #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample),
		.regs(regs_q),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	flac_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	flac_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.regs(regs_q),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.result(result)
	);

endmodule

// File: rtl/flac_front.sv
// front end: fault check, clamp, running median and slew limited ema
module flac_front #(
	parameter int HISTORY_DEPTH = flac_pkg::HISTORY_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	flac_sample_if.sink sample,
	input flac_pkg::cfg_t regs,
	output logic push_valid,
	input logic push_ready,
	output flac_pkg::work_t push_data
);
	import flac_pkg::*;

	localparam int PTR_W = $clog2(HISTORY_DEPTH);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam logic signed [SMOOTH_W:0] SLEW_POS = (SMOOTH_W+1)'(SLEW_LIMIT);
	localparam logic signed [SMOOTH_W:0] SLEW_NEG = -SLEW_POS;

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_RANK = 4'b0010,
		F_EMA = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t state_q;
	logic [ADC_BITS-1:0] hist_q [HISTORY_DEPTH];
	logic [PTR_W-1:0] pos_q;
	logic [CNT_W-1:0] fill_q;
	logic [PTR_W-1:0] cand_q;
	logic [ADC_BITS-1:0] med_q;
	logic [ADC_BITS-1:0] raw_q;
	logic fault_q;
	logic [SMOOTH_W-1:0] smooth_q;
	logic primed_q;

	logic accept;
	logic [ADC_BITS-1:0] s, lo, hi, clamped;
	logic fault;
	logic [ADC_BITS-1:0] cand;
	logic [HISTORY_DEPTH-1:0] below;
	logic [CNT_W-1:0] rank;
	logic rank_last;
	logic signed [SMOOTH_W:0] diff, step, step_lim, smooth_nxt;
	logic [SMOOTH_W:0] rnd_sum;
	logic [ADC_BITS:0] rnd;
	logic [ADC_BITS-1:0] filt;

	assign sample.ready = (state_q == F_IDLE);
	assign accept = sample.valid && sample.ready;
	assign s = sample.adc_sample;

	always_comb begin
		lo = (regs.cal_empty < regs.cal_full) ? regs.cal_empty : regs.cal_full;
		hi = (regs.cal_empty < regs.cal_full) ? regs.cal_full : regs.cal_empty;
		fault = (s >= RAIL_HIGH) || (s <= RAIL_LOW) ||
			({1'b0, s} > ({1'b0, hi} + FAR_MARGIN)) ||
			(({1'b0, s} + FAR_MARGIN) < {1'b0, lo});
		if (s < lo) begin
			clamped = lo;
		end else if (s > hi) begin
			clamped = hi;
		end else begin
			clamped = s;
		end
	end

	// stable rank of the candidate among the filled entries
	always_comb begin
		cand = hist_q[cand_q];
		for (int k = 0; k < HISTORY_DEPTH; k++) begin
			below[k] = (CNT_W'(k) < fill_q) &&
				((hist_q[k] < cand) || ((hist_q[k] == cand) && (PTR_W'(k) < cand_q)));
		end
		rank = CNT_W'($countones(below));
		rank_last = (CNT_W'(cand_q) == (fill_q - CNT_W'(1)));
	end

	always_comb begin
		diff = $signed({1'b0, med_q, {FRAC_BITS{1'b0}}}) - $signed({1'b0, smooth_q});
		step = diff >>> 2;
		if (step > SLEW_POS) begin
			step_lim = SLEW_POS;
		end else if (step < SLEW_NEG) begin
			step_lim = SLEW_NEG;
		end else begin
			step_lim = step;
		end
		smooth_nxt = $signed({1'b0, smooth_q}) + step_lim;
		rnd_sum = {1'b0, smooth_q} + (SMOOTH_W+1)'(1 << (FRAC_BITS - 1));
		rnd = rnd_sum[SMOOTH_W:FRAC_BITS];
		filt = rnd[ADC_BITS] ? {ADC_BITS{1'b1}} : rnd[ADC_BITS-1:0];
	end

	assign push_valid = (state_q == F_PUSH);
	assign push_data.fault = fault_q;
	assign push_data.value = fault_q ? raw_q : filt;

	always_ff @(posedge clk) begin
		if (accept && !fault) begin
			hist_q[pos_q] <= clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			pos_q <= '0;
			fill_q <= '0;
			cand_q <= '0;
			smooth_q <= '0;
			primed_q <= 1'b0;
			fault_q <= 1'b0;
			raw_q <= '0;
			med_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						raw_q <= s;
						fault_q <= fault;
						cand_q <= '0;
						if (fault) begin
							pos_q <= '0;
							fill_q <= '0;
							smooth_q <= '0;
							primed_q <= 1'b0;
							state_q <= F_PUSH;
						end else begin
							pos_q <= (pos_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : pos_q + PTR_W'(1);
							if (fill_q != CNT_W'(HISTORY_DEPTH)) begin
								fill_q <= fill_q + CNT_W'(1);
							end
							state_q <= F_RANK;
						end
					end
				end
				F_RANK: begin
					if (rank == (fill_q >> 1)) begin
						med_q <= cand;
					end
					if (rank_last) begin
						state_q <= F_EMA;
					end else begin
						cand_q <= cand_q + PTR_W'(1);
					end
				end
				F_EMA: begin
					if (!primed_q) begin
						smooth_q <= {med_q, {FRAC_BITS{1'b0}}};
						primed_q <= 1'b1;
					end else begin
						smooth_q <= smooth_nxt[SMOOTH_W-1:0];
					end
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (push_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/flac_queue.sv
// two entry queue between front and back end
module flac_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input flac_pkg::work_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output flac_pkg::work_t pop_data
);
	import flac_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	work_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_data = mem_q[rd_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/flac_back.sv
// back end: status checks, segment search, serial divide for the height
module flac_back (
	input logic clk,
	input logic arst_n,
	input flac_pkg::cfg_t regs,
	input logic pop_valid,
	output logic pop_ready,
	input flac_pkg::work_t pop_data,
	flac_result_if.source result
);
	import flac_pkg::*;

	localparam int STEP_W = $clog2(DIV_STEPS);

	typedef enum logic [5:0] {
		B_IDLE = 6'b000001,
		B_SEG = 6'b000010,
		B_MUL = 6'b000100,
		B_DIV = 6'b001000,
		B_FIN = 6'b010000,
		B_OUT = 6'b100000
	} bstate_t;

	bstate_t state_q;
	work_t item_q;
	status_t status_q;
	logic [1:0] seg_q;
	logic [ADC_BITS-1:0] span_q, off_q;
	logic [HEIGHT_W-1:0] u_q, stroke_q, height_q;
	logic [SPAN_W-1:0] rem_q, den_q;
	logic [HEIGHT_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic res_valid_q;
	logic [ADC_BITS-1:0] res_raw_q;
	logic [HEIGHT_W-1:0] res_height_q;
	status_t res_status_q;

	logic [ADC_BITS-1:0] x [NUM_ANCHORS];
	logic up, down, asc, found, at_empty;
	logic [3:0] hit;
	logic [ADC_BITS-1:0] seg_span [4];
	logic [ADC_BITS-1:0] seg_off [4];
	logic [1:0] seg_sel;
	logic [HEIGHT_W-1:0] d, u, stroke;
	logic [ADC_BITS-1:0] v;
	logic [SPAN_W-1:0] lin;
	logic [NUM_W-1:0] num;
	logic [SPAN_W:0] trial;
	logic ge;
	logic [HEIGHT_W:0] sum;
	logic out_free;

	assign pop_ready = (state_q == B_IDLE);
	assign v = item_q.value;
	assign d = regs.tank_diameter;

	always_comb begin
		x[0] = regs.cal_empty;
		x[1] = regs.cal_quarter;
		x[2] = regs.cal_half;
		x[3] = regs.cal_three_quarter;
		x[4] = regs.cal_full;
		up = 1'b1;
		down = 1'b1;
		for (int i = 1; i < NUM_ANCHORS; i++) begin
			if (x[i] < x[i-1]) up = 1'b0;
			if (x[i] > x[i-1]) down = 1'b0;
		end
		asc = (x[4] >= x[0]);
		for (int i = 0; i < 4; i++) begin
			hit[i] = (x[i] != x[i+1]) && (asc ? (v >= x[i] && v <= x[i+1])
				: (v <= x[i] && v >= x[i+1]));
			seg_span[i] = asc ? x[i+1] - x[i] : x[i] - x[i+1];
			seg_off[i] = asc ? v - x[i] : x[i] - v;
		end
		found = |hit;
		seg_sel = 2'd0;
		for (int i = 3; i >= 0; i--) begin
			if (hit[i]) seg_sel = 2'(i);
		end
		at_empty = asc ? (v <= x[0]) : (v >= x[0]);
		if (regs.reach_height != '0 && regs.reach_height <= d) begin
			u = d - regs.reach_height;
		end else if (regs.unreached_height > d) begin
			u = d;
		end else begin
			u = regs.unreached_height;
		end
		stroke = d - u;
	end

	always_comb begin
		case (seg_q)
			2'd0: lin = SPAN_W'(off_q);
			2'd1: lin = SPAN_W'(span_q) + SPAN_W'(off_q);
			2'd2: lin = {1'b0, span_q, 1'b0} + SPAN_W'(off_q);
			default: lin = {1'b0, span_q, 1'b0} + SPAN_W'(span_q) + SPAN_W'(off_q);
		endcase
		num = NUM_W'(stroke_q) * NUM_W'(lin) + NUM_W'({span_q, 1'b0});
		trial = {rem_q, quo_q[HEIGHT_W-1]};
		ge = (trial >= {1'b0, den_q});
		sum = {1'b0, u_q} + {1'b0, quo_q};
	end

	assign out_free = !res_valid_q || result.ready;
	assign result.valid = res_valid_q;
	assign result.filtered_raw = res_raw_q;
	assign result.liquid_height = res_height_q;
	assign result.status = res_status_q;

	always_ff @(posedge clk) begin
		if (state_q == B_OUT && out_free) begin
			res_raw_q <= item_q.value;
			res_height_q <= height_q;
			res_status_q <= status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			res_valid_q <= 1'b0;
			item_q <= '0;
			status_q <= ST_ONLINE;
			seg_q <= '0;
			span_q <= '0;
			off_q <= '0;
			u_q <= '0;
			stroke_q <= '0;
			height_q <= '0;
			rem_q <= '0;
			den_q <= '0;
			quo_q <= '0;
			step_q <= '0;
		end else begin
			if (res_valid_q && result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						item_q <= pop_data;
						state_q <= B_SEG;
					end
				end
				B_SEG: begin
					height_q <= '0;
					seg_q <= seg_sel;
					span_q <= seg_span[seg_sel];
					off_q <= seg_off[seg_sel];
					u_q <= u;
					stroke_q <= stroke;
					state_q <= B_OUT;
					if (item_q.fault) begin
						status_q <= ST_SENSOR_FAULT;
					end else if (!up && !down) begin
						status_q <= ST_NOT_MONOTONIC;
					end else if (d == '0 || stroke == '0) begin
						status_q <= ST_GEOMETRY_INVALID;
					end else begin
						status_q <= ST_ONLINE;
						if (found) begin
							state_q <= B_MUL;
						end else begin
							height_q <= at_empty ? u : d;
						end
					end
				end
				B_MUL: begin
					rem_q <= num[NUM_W-1:HEIGHT_W];
					quo_q <= num[HEIGHT_W-1:0];
					den_q <= {span_q, 2'b00};
					step_q <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					rem_q <= ge ? SPAN_W'(trial - {1'b0, den_q}) : trial[SPAN_W-1:0];
					quo_q <= {quo_q[HEIGHT_W-2:0], ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= B_FIN;
					end
				end
				B_FIN: begin
					height_q <= (sum > {1'b0, d}) ? d : sum[HEIGHT_W-1:0];
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (out_free) begin
						res_valid_q <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
